FILE: src/ntt_q3329_forward_inverse_assert.svh
// Assertion macros for the NTT block
`ifndef NTT_Q3329_FORWARD_INVERSE_ASSERT_SVH
`define NTT_Q3329_FORWARD_INVERSE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NTT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/ntt_pkg.sv
package ntt_pkg;
  localparam int NCOEF = 256;
  localparam int LANES = 4;
  localparam logic signed [15:0] QMOD = 16'sd3329;
  localparam logic [15:0] QINV = 16'd62209;
  localparam logic signed [15:0] INV_SCALE = 16'sd1441;

  typedef struct packed {
    logic signed [15:0] coef_d;
    logic signed [15:0] coef_c;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_a;
  } ntt_in_t;

  typedef struct packed {
    logic              final_group;
    logic signed [15:0] res_d;
    logic signed [15:0] res_c;
    logic signed [15:0] res_b;
    logic signed [15:0] res_a;
  } ntt_out_t;

  typedef struct packed {
    logic              inv;
    logic signed [15:0] zeta;
  } ntt_bf_ctl_t;

  function automatic logic signed [15:0] zeta_rom(input logic [6:0] i);
    logic signed [15:0] z;
    case (i)
      7'd0: z = -16'sd1044; 7'd1: z = -16'sd758; 7'd2: z = -16'sd359; 7'd3: z = -16'sd1517;
      7'd4: z = 16'sd1493; 7'd5: z = 16'sd1422; 7'd6: z = 16'sd287; 7'd7: z = 16'sd202;
      7'd8: z = -16'sd171; 7'd9: z = 16'sd622; 7'd10: z = 16'sd1577; 7'd11: z = 16'sd182;
      7'd12: z = 16'sd962; 7'd13: z = -16'sd1202; 7'd14: z = -16'sd1474; 7'd15: z = 16'sd1468;
      7'd16: z = 16'sd573; 7'd17: z = -16'sd1325; 7'd18: z = 16'sd264; 7'd19: z = 16'sd383;
      7'd20: z = -16'sd829; 7'd21: z = 16'sd1458; 7'd22: z = -16'sd1602; 7'd23: z = -16'sd130;
      7'd24: z = -16'sd681; 7'd25: z = 16'sd1017; 7'd26: z = 16'sd732; 7'd27: z = 16'sd608;
      7'd28: z = -16'sd1542; 7'd29: z = 16'sd411; 7'd30: z = -16'sd205; 7'd31: z = -16'sd1571;
      7'd32: z = 16'sd1223; 7'd33: z = 16'sd652; 7'd34: z = -16'sd552; 7'd35: z = 16'sd1015;
      7'd36: z = -16'sd1293; 7'd37: z = 16'sd1491; 7'd38: z = -16'sd282; 7'd39: z = -16'sd1544;
      7'd40: z = 16'sd516; 7'd41: z = -16'sd8; 7'd42: z = -16'sd320; 7'd43: z = -16'sd666;
      7'd44: z = -16'sd1618; 7'd45: z = -16'sd1162; 7'd46: z = 16'sd126; 7'd47: z = 16'sd1469;
      7'd48: z = -16'sd853; 7'd49: z = -16'sd90; 7'd50: z = -16'sd271; 7'd51: z = 16'sd830;
      7'd52: z = 16'sd107; 7'd53: z = -16'sd1421; 7'd54: z = -16'sd247; 7'd55: z = -16'sd951;
      7'd56: z = -16'sd398; 7'd57: z = 16'sd961; 7'd58: z = -16'sd1508; 7'd59: z = -16'sd725;
      7'd60: z = 16'sd448; 7'd61: z = -16'sd1065; 7'd62: z = 16'sd677; 7'd63: z = -16'sd1275;
      7'd64: z = -16'sd1103; 7'd65: z = 16'sd430; 7'd66: z = 16'sd555; 7'd67: z = 16'sd843;
      7'd68: z = -16'sd1251; 7'd69: z = 16'sd871; 7'd70: z = 16'sd1550; 7'd71: z = 16'sd105;
      7'd72: z = 16'sd422; 7'd73: z = 16'sd587; 7'd74: z = 16'sd177; 7'd75: z = -16'sd235;
      7'd76: z = -16'sd291; 7'd77: z = -16'sd460; 7'd78: z = 16'sd1574; 7'd79: z = 16'sd1653;
      7'd80: z = -16'sd246; 7'd81: z = 16'sd778; 7'd82: z = 16'sd1159; 7'd83: z = -16'sd147;
      7'd84: z = -16'sd777; 7'd85: z = 16'sd1483; 7'd86: z = -16'sd602; 7'd87: z = 16'sd1119;
      7'd88: z = -16'sd1590; 7'd89: z = 16'sd644; 7'd90: z = -16'sd872; 7'd91: z = 16'sd349;
      7'd92: z = 16'sd418; 7'd93: z = 16'sd329; 7'd94: z = -16'sd156; 7'd95: z = -16'sd75;
      7'd96: z = 16'sd817; 7'd97: z = 16'sd1097; 7'd98: z = 16'sd603; 7'd99: z = 16'sd610;
      7'd100: z = 16'sd1322; 7'd101: z = -16'sd1285; 7'd102: z = -16'sd1465; 7'd103: z = 16'sd384;
      7'd104: z = -16'sd1215; 7'd105: z = -16'sd136; 7'd106: z = 16'sd1218; 7'd107: z = -16'sd1335;
      7'd108: z = -16'sd874; 7'd109: z = 16'sd220; 7'd110: z = -16'sd1187; 7'd111: z = -16'sd1659;
      7'd112: z = -16'sd1185; 7'd113: z = -16'sd1530; 7'd114: z = -16'sd1278; 7'd115: z = 16'sd794;
      7'd116: z = -16'sd1510; 7'd117: z = -16'sd854; 7'd118: z = -16'sd870; 7'd119: z = 16'sd478;
      7'd120: z = -16'sd108; 7'd121: z = -16'sd308; 7'd122: z = 16'sd996; 7'd123: z = 16'sd991;
      7'd124: z = 16'sd958; 7'd125: z = -16'sd1460; 7'd126: z = 16'sd1522; 7'd127: z = 16'sd1628;
      default: z = 16'sd0;
    endcase
    return z;
  endfunction
endpackage

FILE: src/ntt_mont.sv
// Montgomery product, two register stages
module ntt_mont
  import ntt_pkg::*;
(
  input  logic               clk,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [15:0] r
);
  logic signed [31:0] p_r;
  logic signed [31:0] p2_r;
  logic signed [15:0] t_r;
  logic signed [31:0] d;
  always_ff @(posedge clk) begin
    p_r <= a * b;
    p2_r <= p_r;
    t_r <= p_r[15:0] * QINV;
  end
  always_comb begin
    d = p2_r - t_r * 32'(QMOD);
  end
  assign r = d[31:16];
endmodule

FILE: src/ntt_bfly.sv
// Shared butterfly: results are formed from the registered operands and the registered Montgomery product
module ntt_bfly
  import ntt_pkg::*;
(
  input  logic               clk,
  input  ntt_bf_ctl_t        ctl,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic signed [15:0] ra,
  output logic signed [15:0] rb
);
  logic signed [15:0] a1_r, ssum_r, bt_r, md, bar;
  logic signed [15:0] ssum, sdif;
  logic signed [31:0] bx;
  logic signed [15:0] bt;

  always_comb begin
    ssum = a + b;
    sdif = a - b;
    bx = 32'sd20159 * ssum + 32'sd33554432;
    bt = 16'(bx >>> 26);
    bar = ssum_r - 16'(bt_r * QMOD);
  end

  ntt_mont u_m (.clk(clk), .a(ctl.zeta), .b(ctl.inv ? sdif : b), .r(md));

  always_ff @(posedge clk) begin
    a1_r <= a;
    ssum_r <= ssum;
    bt_r <= bt;
  end

  assign ra = ctl.inv ? bar : a1_r + md;
  assign rb = ctl.inv ? md : a1_r - md;
endmodule

FILE: src/ntt_q3329_forward_inverse.sv
// NTT modulo 3329 over one 256-coefficient polynomial.
// Input channel: 64 requests of four signed coefficients, index order.
// Each accepted request is written to the store one lane per cycle, so no
// new request is taken until all four lanes are written.
// Config: cfg_we/cfg_wdata set direction (0 forward, 1 inverse+scale);
// sampled when the last load request is accepted.
// After the 64th load the block runs 7 layers x 128 butterflies on one
// shared butterfly unit, each as two reads, the butterfly pipeline and two
// writes; the inverse adds a 256-coefficient scaling pass through the same steps.
// Results: 64 requests in index order, final_group set on the last; each
// takes four store reads, then the handshake, held while out_stall is high.
// out_stall holds the current result; in_stall is high except in the load state.
// Reset (rst_n low, synchronous) clears the counters and direction and
// returns to loading; the store is not cleared.
module ntt_q3329_forward_inverse
  import ntt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ntt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ntt_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);
`include "ntt_q3329_forward_inverse_assert.svh"
  typedef enum logic [4:0] {
    S_LOAD = 5'b00001, S_FILL = 5'b00010, S_BF = 5'b00100, S_EMIT = 5'b01000,
    S_OUT = 5'b10000
  } st_t;
  st_t st_r;
  logic [15:0] mem [NCOEF];
  logic [5:0] lc_r;
  logic dir_r, run_inv_r, scale_r;
  logic [2:0] lay_r;
  logic [6:0] bi_r;
  logic [2:0] ph_r;
  logic [7:0] ja, jb, ea;
  logic signed [15:0] av_r, bv_r, ra, rb, sm;
  logic [7:0] sh;
  logic [1:0] lane_r;
  logic [5:0] oi_r;
  ntt_in_t ld_r;
  logic [15:0] fill_d;
  ntt_bf_ctl_t ctl;
  logic [7:0] len, g;
  logic [6:0] zi;

  always_comb begin
    len = run_inv_r ? (8'd2 << lay_r) : (8'd128 >> lay_r);
    sh = run_inv_r ? 8'(lay_r + 3'd1) : 8'(3'd7 - lay_r);
    g = 8'({1'b0, bi_r} >> sh);
    ja = 8'((g << (sh + 8'd1)) | ({1'b0, bi_r} & (len - 8'd1)));
    jb = ja + len;
    zi = run_inv_r ? 7'((8'd255 >> sh) - g) : 7'((8'd128 >> sh) + g);
    ctl.inv = run_inv_r;
    ctl.zeta = scale_r ? INV_SCALE : (run_inv_r ? -zeta_rom(zi) : zeta_rom(zi));
    ea = {oi_r, lane_r};
  end

  always_comb begin
    case (lane_r)
      2'd0: fill_d = ld_r.coef_a;
      2'd1: fill_d = ld_r.coef_b;
      2'd2: fill_d = ld_r.coef_c;
      default: fill_d = ld_r.coef_d;
    endcase
  end

  ntt_bfly u_bf (.clk(clk), .ctl(ctl), .a(scale_r ? 16'sd0 : av_r), .b(bv_r),
    .ra(ra), .rb(rb));
  assign sm = rb;

  assign in_stall = (st_r != S_LOAD);
  assign out_valid = (st_r == S_OUT);

  // scale pass: a=0 and b=-c through the inverse path gives mont(1441*c)
  always_ff @(posedge clk) begin
    if (st_r == S_LOAD && in_valid) begin
      ld_r <= in_data;
    end else if (st_r == S_FILL) begin
      mem[{lc_r, lane_r}] <= fill_d;
    end else if (st_r == S_BF && ph_r == 3'd0) begin
      av_r <= mem[scale_r ? {bi_r, 1'b0} : ja];
    end else if (st_r == S_BF && ph_r == 3'd1) begin
      bv_r <= scale_r ? -mem[{bi_r, lane_r[0]}] : mem[jb];
    end else if (st_r == S_BF && ph_r == 3'd4) begin
      if (scale_r) mem[{bi_r, lane_r[0]}] <= sm;
      else mem[ja] <= ra;
    end else if (st_r == S_BF && ph_r == 3'd5) begin
      if (!scale_r) mem[jb] <= rb;
    end else if (st_r == S_EMIT) begin
      case (lane_r)
        2'd0: out_data.res_a <= mem[ea];
        2'd1: out_data.res_b <= mem[ea];
        2'd2: out_data.res_c <= mem[ea];
        default: out_data.res_d <= mem[ea];
      endcase
      out_data.final_group <= (oi_r == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; lc_r <= '0; dir_r <= 1'b0; run_inv_r <= 1'b0;
      scale_r <= 1'b0; lay_r <= '0; bi_r <= '0; ph_r <= '0;
      lane_r <= '0; oi_r <= '0;
    end else begin
      if (cfg_we) dir_r <= cfg_wdata;
      case (st_r)
        S_LOAD: if (in_valid) begin
          st_r <= S_FILL;
          lane_r <= '0;
          if (lc_r == 6'd63) run_inv_r <= dir_r;
        end
        S_FILL: begin
          lane_r <= lane_r + 2'd1;
          if (lane_r == 2'd3) begin
            lc_r <= lc_r + 6'd1;
            if (lc_r == 6'd63) begin
              st_r <= S_BF; lay_r <= '0; bi_r <= '0; ph_r <= '0; scale_r <= 1'b0;
            end else st_r <= S_LOAD;
          end
        end
        S_BF: begin
          if (ph_r == 3'd5) begin
            ph_r <= '0;
            if (scale_r) begin
              lane_r[0] <= ~lane_r[0];
              if (lane_r[0]) begin
                bi_r <= bi_r + 7'd1;
                if (bi_r == 7'd127) begin
                  st_r <= S_EMIT; scale_r <= 1'b0; oi_r <= '0;
                end
              end
            end else begin
              bi_r <= bi_r + 7'd1;
              if (bi_r == 7'd127) begin
                lay_r <= lay_r + 3'd1;
                if (lay_r == 3'd6) begin
                  if (run_inv_r) scale_r <= 1'b1;
                  else begin
                    st_r <= S_EMIT; lane_r <= '0; oi_r <= '0;
                  end
                end
              end
            end
          end else ph_r <= ph_r + 3'd1;
        end
        S_EMIT: begin
          lane_r <= lane_r + 2'd1;
          if (lane_r == 2'd3) st_r <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          if (oi_r == 6'd63) st_r <= S_LOAD;
          else st_r <= S_EMIT;
          oi_r <= oi_r + 6'd1;
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  `NTT_ASSERT_IMPL(a_busy_stall, clk, rst_n, st_r != S_LOAD, in_stall)
  `NTT_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `NTT_ASSERT_IMPL(a_final_last, clk, rst_n, out_valid && out_data.final_group, oi_r == 6'd63)
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import ntt_pkg::*;
();

  localparam int NITEMS = 64;
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;
  localparam int DRAIN_CYCLES = 6000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ntt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ntt_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;

  ntt_q3329_forward_inverse DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  logic signed [15:0] poly [NCOEF];
  logic [5:0]         loaded;
  logic               dir_shadow;
  ntt_out_t           expected_q [$];
  int                 errors = 0;
  bit                 hold_recv = 1'b0;

  function automatic logic signed [15:0] mont(input logic signed [31:0] a);
    logic signed [15:0] t;
    logic signed [31:0] r;
    t = 16'(a * 32'sd62209);
    r = (a - 32'(t) * 32'sd3329) >>> 16;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] fqmul(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    return mont(32'(a) * 32'(b));
  endfunction

  function automatic logic signed [15:0] barrett(input logic signed [15:0] a);
    logic signed [31:0] t;
    t = (32'sd20159 * 32'(a) + 32'sd33554432) >>> 26;
    return 16'(32'(a) - t * 32'sd3329);
  endfunction

  task automatic transform_poly();
    int g, j;
    logic signed [15:0] t, a, b, s, d, z;
    if (dir_shadow == DIR_FWD) begin
      for (int len = 128; len >= 2; len >>= 1)
        for (int i = 0; i < 128; i++) begin
          g = i / len;
          j = g * 2 * len + i % len;
          t = fqmul(zeta_rom(7'((128 / len + g) & 127)), poly[j + len]);
          a = poly[j];
          poly[j] = a + t;
          poly[j + len] = a - t;
        end
    end else begin
      for (int len = 2; len <= 128; len <<= 1)
        for (int i = 0; i < 128; i++) begin
          g = i / len;
          j = g * 2 * len + i % len;
          z = -zeta_rom(7'((256 / len - 1 - g) & 127));
          a = poly[j];
          b = poly[j + len];
          s = barrett(a + b);
          d = fqmul(z, 16'(a - b));
          if (len == 128) begin
            s = fqmul(s, INV_SCALE);
            d = fqmul(d, INV_SCALE);
          end
          poly[j] = s;
          poly[j + len] = d;
        end
    end
  endtask

  task automatic load_request(input ntt_in_t r);
    ntt_out_t e;
    poly[loaded * LANES]     = r.coef_a;
    poly[loaded * LANES + 1] = r.coef_b;
    poly[loaded * LANES + 2] = r.coef_c;
    poly[loaded * LANES + 3] = r.coef_d;
    loaded++;
    if (loaded == 0) begin
      transform_poly();
      for (int k = 0; k < NITEMS; k++) begin
        e.res_a = poly[k * LANES];
        e.res_b = poly[k * LANES + 1];
        e.res_c = poly[k * LANES + 2];
        e.res_d = poly[k * LANES + 3];
        e.final_group = (k == NITEMS - 1);
        expected_q.push_back(e);
      end
    end
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(input ntt_in_t r, input bit gaps);
    if (gaps && $urandom_range(0, 1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    load_request(r);
  endtask

  task automatic set_direction(input logic d);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dir_shadow = d;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic ntt_in_t random_request(input int mode);
    ntt_in_t r;
    r = {$urandom, $urandom};
    if (mode == 1) begin
      r.coef_a = 16'($urandom_range(0, 6657) - 3328);
      r.coef_b = 16'($urandom_range(0, 6657) - 3328);
      r.coef_c = 16'($urandom_range(0, 6657) - 3328);
      r.coef_d = 16'($urandom_range(0, 6657) - 3328);
    end
    return r;
  endfunction

  // directed table: extremes and sign patterns, then filler
  ntt_in_t corner_tbl [8] = '{
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000},
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
    '{16'shffff, 16'shffff, 16'shffff, 16'shffff},
    '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000},
    '{16'sd3328, -16'sd3328, 16'sd3329, -16'sd3329},
    '{16'sd1, -16'sd1, 16'sd1664, -16'sd1665},
    '{16'sh5555, 16'shaaaa, 16'sh0f0f, 16'shf0f0}
  };

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_recv)
        out_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0)
        out_stall <= 1'b1;
      else
        out_stall <= 1'b0;
    end
  end

  // long hold-off while the sender keeps offering
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_recv = 1'b1;
    repeat (9000) @(posedge clk);
    hold_recv = 1'b0;
  end

  always @(posedge clk) begin
    ntt_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("ntt_q3329_forward_inverse test failed");
    $finish;
  end

  initial begin
    ntt_in_t r;
    loaded = '0;
    dir_shadow = DIR_FWD;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // forward: corner rows first, then full-range random
    for (int i = 0; i < NITEMS; i++) begin
      r = (i < 8) ? corner_tbl[i] : random_request(0);
      send_request(r, 1'b0);
    end

    // next polynomial is offered while the first one's results are held off
    for (int i = 0; i < NITEMS; i++) begin
      r = (i < 8) ? corner_tbl[7 - i] : random_request(i % 2);
      // direction change mid-load; only the value at the last load counts
      if (i == 10) set_direction(DIR_INV);
      if (i == 30) set_direction(DIR_FWD);
      if (i == 50) set_direction(DIR_INV);
      send_request(r, 1'b1);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ntt_q3329_forward_inverse test passed");
    end else begin
      $display("ntt_q3329_forward_inverse test failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/ntt_pkg.sv
src/ntt_mont.sv
src/ntt_bfly.sv
src/ntt_q3329_forward_inverse.sv
sim/tb_top.sv
